// ----- rtl/core/drm_pkg.sv -----
// package of types and constants for the dirty rectangle merger
package drm_pkg;

    localparam int unsigned CoordW = 12;
    localparam int unsigned ThrW   = 24;
    localparam int unsigned TotalW = 5;
    localparam int unsigned CompactAbove = 3;

    typedef enum logic {
        REQ_MARK  = 1'b0,
        REQ_FLUSH = 1'b1
    } t_req;

    typedef struct packed {
        logic              req_type;
        logic [CoordW-1:0] rect_x_start;
        logic [CoordW-1:0] rect_y_start;
        logic [CoordW-1:0] rect_x_end;
        logic [CoordW-1:0] rect_y_end;
    } t_in_item;

    typedef struct packed {
        logic [CoordW-1:0] out_x_start;
        logic [CoordW-1:0] out_y_start;
        logic [CoordW-1:0] out_x_end;
        logic [CoordW-1:0] out_y_end;
        logic [TotalW-1:0] out_total;
        logic              is_empty;
        logic              is_last;
    } t_out_item;

endpackage

// ----- rtl/core/dirty_rect_merger.sv -----
// top level of the dirty rectangle merger
//
// Command channel: an item (mark or flush) is taken when start is high
// and busy is low. Configuration: i_cfg_we writes the overlap threshold
// from i_cfg_wdata in the same edge; the user must write it only while
// the block is idle, which the block itself does not enforce. A mark
// scans the table newest to oldest, one entry after another (memory read,
// compare and area multiply, then threshold test and write-back), and
// busy stays high until the scan ends. A flush with more than three
// entries first compacts the table: each entry is checked against the
// kept ones. Results then come one at a time, each on o_result with o_valid
// high for exactly one cycle; the receiver cannot hold them off.
// A flush of an empty table gives one beat flagged empty in the next cycle.
// Reset empties the table (count to zero) and sets the threshold to 256;
// table contents are not cleared.
module dirty_rect_merger #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  drm_pkg::t_in_item    i_item,
    output logic                 o_valid,
    output drm_pkg::t_out_item   o_result,
    input  logic                 i_cfg_we,
    input  logic [drm_pkg::ThrW-1:0] i_cfg_wdata
);
    import drm_pkg::*;

    localparam int unsigned COORD_BITS = CoordW;
    localparam int unsigned AW = $clog2(TABLE_ENTRIES);
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned RW = 4 * COORD_BITS;
    localparam int unsigned Half = TABLE_ENTRIES / 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
    } t_box;

    typedef enum logic [3:0] {
        S_IDLE, S_MRD, S_MCMP, S_MAREA, S_MFOLD,
        S_CRD_I, S_CWAIT_I, S_CRD_J, S_CCMP, S_CAREA,
        S_ORD, S_OWAIT, S_OEMIT
    } t_state;

    t_state          r_state;
    logic [ThrW-1:0] r_thr;
    logic [CW-1:0]   r_count, r_kept, r_i, r_j;
    logic [ThrW-1:0] r_scan_thr;
    t_box            r_new, r_ent;
    logic            r_ok;
    logic [2*COORD_BITS-1:0] r_area;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    t_box            wdata, rdata;
    logic [RW-1:0]   rdata_raw;

    drm_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata_raw)
    );
    assign rdata = t_box'(rdata_raw);

    // overlap test between rdata (entry) and r_new
    logic overlap, contain;
    logic [COORD_BITS-1:0] ov_w, ov_h;
    t_box bbox;
    always_comb begin
        overlap = !(rdata.xe <= r_new.xs || rdata.xs >= r_new.xe ||
                    rdata.ye <= r_new.ys || rdata.ys >= r_new.ye);
        ov_w = ((rdata.xe < r_new.xe) ? rdata.xe : r_new.xe) -
               ((rdata.xs > r_new.xs) ? rdata.xs : r_new.xs);
        ov_h = ((rdata.ye < r_new.ye) ? rdata.ye : r_new.ye) -
               ((rdata.ys > r_new.ys) ? rdata.ys : r_new.ys);
        contain = (rdata.xs <= r_new.xs && rdata.ys <= r_new.ys &&
                   rdata.xe >= r_new.xe && rdata.ye >= r_new.ye) ||
                  (r_new.xs <= rdata.xs && r_new.ys <= rdata.ys &&
                   r_new.xe >= rdata.xe && r_new.ye >= rdata.ye);
    end

    // bounding box of the held entry and r_new
    always_comb begin
        bbox.xs = (r_ent.xs < r_new.xs) ? r_ent.xs : r_new.xs;
        bbox.ys = (r_ent.ys < r_new.ys) ? r_ent.ys : r_new.ys;
        bbox.xe = (r_ent.xe > r_new.xe) ? r_ent.xe : r_new.xe;
        bbox.ye = (r_ent.ye > r_new.ye) ? r_ent.ye : r_new.ye;
    end

    logic cover_q;
    logic merge_ok;
    assign merge_ok = r_ok && ({{(ThrW){1'b0}}, r_area} >= {{(2*COORD_BITS){1'b0}}, r_scan_thr}
                      || cover_q);

    t_box in_box;
    assign in_box = '{xs: i_item.rect_x_start[COORD_BITS-1:0],
                      ys: i_item.rect_y_start[COORD_BITS-1:0],
                      xe: i_item.rect_x_end[COORD_BITS-1:0],
                      ye: i_item.rect_y_end[COORD_BITS-1:0]};

    // memory port control
    always_comb begin
        we    = 1'b0;
        waddr = r_j[AW-1:0];
        wdata = bbox;
        raddr = r_j[AW-1:0];
        unique case (r_state)
            S_MAREA: begin
                we = merge_ok;
            end
            S_MFOLD: begin
                we    = 1'b1;
                waddr = (r_count < CW'(TABLE_ENTRIES)) ? r_count[AW-1:0] : '0;
                wdata = (r_count < CW'(TABLE_ENTRIES)) ? r_new : bbox;
            end
            S_CRD_I, S_CWAIT_I, S_ORD, S_OWAIT: begin
                raddr = r_i[AW-1:0];
            end
            S_CAREA: begin
                we    = merge_ok || (r_j + 1'b1 == r_kept);
                waddr = merge_ok ? r_j[AW-1:0] : r_kept[AW-1:0];
                wdata = merge_ok ? bbox : r_new;
            end
            default: ;
        endcase
    end

    // control sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr   <= ThrW'(256);
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= (r_state == S_OEMIT) ||
                       (r_state == S_IDLE && start &&
                        i_item.req_type == REQ_FLUSH && r_count == '0);
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_new <= in_box;
                        if (i_item.req_type == REQ_FLUSH) begin
                            if (r_count == '0) begin
                                o_result <= '{default: '0, is_empty: 1'b1,
                                              is_last: 1'b1};
                            end else if (r_count > CW'(CompactAbove)) begin
                                r_kept     <= CW'(1);
                                r_i        <= CW'(1);
                                r_scan_thr <= r_thr;
                                r_state    <= S_CRD_I;
                            end else begin
                                r_i     <= '0;
                                r_kept  <= r_count;
                                r_state <= S_ORD;
                            end
                        end else if (in_box.xs < in_box.xe && in_box.ys < in_box.ye) begin
                            r_scan_thr <= (r_count >= CW'(Half)) ? '0 : r_thr;
                            if (r_count == '0) begin
                                r_state <= S_MFOLD;
                            end else begin
                                r_j     <= r_count - 1'b1;
                                r_state <= S_MRD;
                            end
                        end
                    end
                end
                // mark scan
                S_MRD:  r_state <= S_MCMP;
                S_MCMP: begin
                    r_ent   <= rdata;
                    r_ok    <= overlap;
                    cover_q <= contain;
                    r_area  <= ov_w * ov_h;
                    r_state <= S_MAREA;
                end
                S_MAREA: begin
                    if (merge_ok) begin
                        r_state <= S_IDLE;
                    end else if (r_j == '0) begin
                        r_j     <= '0;
                        r_state <= S_MFOLD;
                    end else begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_MRD;
                    end
                end
                S_MFOLD: begin
                    if (r_count < CW'(TABLE_ENTRIES)) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                // compaction
                S_CRD_I: begin
                    if (r_i == r_count) begin
                        r_i     <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_CWAIT_I;
                    end
                end
                S_CWAIT_I: begin
                    r_new   <= rdata;
                    r_j     <= '0;
                    r_state <= S_CRD_J;
                end
                S_CRD_J: r_state <= S_CCMP;
                S_CCMP: begin
                    r_ent   <= rdata;
                    r_ok    <= overlap;
                    cover_q <= contain;
                    r_area  <= ov_w * ov_h;
                    r_state <= S_CAREA;
                end
                S_CAREA: begin
                    if (merge_ok || r_j + 1'b1 == r_kept) begin
                        if (!merge_ok) r_kept <= r_kept + 1'b1;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_CRD_I;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_CRD_J;
                    end
                end
                // emission
                S_ORD:   r_state <= S_OWAIT;
                S_OWAIT: r_state <= S_OEMIT;
                S_OEMIT: begin
                    o_result <= '{out_x_start: CoordW'(rdata.xs),
                                  out_y_start: CoordW'(rdata.ys),
                                  out_x_end:   CoordW'(rdata.xe),
                                  out_y_end:   CoordW'(rdata.ye),
                                  out_total:   TotalW'(r_kept),
                                  is_empty:    1'b0,
                                  is_last:     (r_i + 1'b1 == r_kept)};
                    if (r_i + 1'b1 == r_kept) begin
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ORD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
endmodule

// ----- rtl/core/drm_ram.sv -----
// generic simple dual port ram (one write port, one read port) with registered read
module drm_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
